[rtl/brds_pkg.sv]
`default_nettype none

package brds_pkg;

    localparam int MAX_DIGITS = 64;
    localparam int CNT_W      = 7;
    localparam int IDX_W      = 6;

    // input width modes
    localparam logic [1:0] IN_W32 = 2'd0;
    localparam logic [1:0] IN_W16 = 2'd1;
    localparam logic [1:0] IN_W64 = 2'd2;

    // output width modes
    localparam logic [1:0] OUT_W8  = 2'd0;
    localparam logic [1:0] OUT_W16 = 2'd1;
    localparam logic [1:0] OUT_W32 = 2'd2;

    // accumulate operations of the shared multiplier
    typedef logic [2:0] mac_op_t;
    localparam mac_op_t MAC_LOAD_HI = 3'd0;  // acc = prod >> 32
    localparam mac_op_t MAC_ADD     = 3'd1;  // acc += prod
    localparam mac_op_t MAC_FOLD    = 3'd2;  // acc = (acc >> 32) + prod
    localparam mac_op_t MAC_LOAD    = 3'd3;  // acc = prod
    localparam mac_op_t MAC_ADD_HI  = 3'd4;  // acc += prod << 32, mod 2^64

    typedef struct packed {
        logic    vld;
        mac_op_t op;
    } mac_cmd_t;

    typedef struct packed {
        logic done;
        logic busy;
    } div_stat_t;

    function automatic logic [63:0] in_trim(input logic [1:0] mode, input logic [63:0] x);
        logic [63:0] r;
        case (mode)
            IN_W32:  r = {32'h0, x[31:0]};
            IN_W16:  r = {48'h0, x[15:0]};
            default: r = x;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] out_trim(input logic [1:0] mode, input logic [63:0] v);
        logic [31:0] r;
        case (mode)
            OUT_W8:  r = {24'h0, v[7:0]};
            OUT_W16: r = {16'h0, v[15:0]};
            default: r = v[31:0];
        endcase
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] digit_total(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] r;
        if (cnt == '0)
            r = CNT_W'(1);
        else if (cnt > CNT_W'(MAX_DIGITS))
            r = CNT_W'(MAX_DIGITS);
        else
            r = cnt;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/brds_mac.sv]
`default_nettype none

module brds_mac
    import brds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mac_cmd_t    cmd,
    input  wire logic [31:0] op_a,
    input  wire logic [31:0] op_b,
    output logic      [63:0] acc
);

    logic [63:0] prod_reg;
    mac_op_t     op_reg;
    logic        vld_reg;
    logic [65:0] acc_reg;
    logic [65:0] acc_next;

    // product registered, then folded into the accumulator on the following cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(op_a) * 64'(op_b);
        op_reg   <= cmd.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= cmd.vld;
    end

    always_comb
    begin
        case (op_reg)
            MAC_LOAD_HI: acc_next = {34'h0, prod_reg[63:32]};
            MAC_ADD:     acc_next = acc_reg + {2'b00, prod_reg};
            MAC_FOLD:    acc_next = {32'h0, acc_reg[65:32]} + {2'b00, prod_reg};
            MAC_LOAD:    acc_next = {2'b00, prod_reg};
            MAC_ADD_HI:  acc_next = {2'b00, acc_reg[63:0] + {prod_reg[31:0], 32'h0}};
            default:     acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg)
            acc_reg <= acc_next;
    end

    assign acc = acc_reg[63:0];

endmodule

`default_nettype wire

[rtl/brds_div.sv]
`default_nettype none

module brds_div
    import brds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output div_stat_t        stat,
    output logic      [63:0] quotient,
    output logic      [31:0] remainder
);

    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [6:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;

    logic [32:0] r_sh;
    logic        ge;
    logic [31:0] rem_next;

    // restoring division, one quotient bit per cycle, MSB first
    assign r_sh     = {rem_reg, quo_reg[63]};
    assign ge       = (r_sh >= {1'b0, divisor});
    assign rem_next = ge ? 32'(r_sh - {1'b0, divisor}) : r_sh[31:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[62:0], ge};
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= 7'd64;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.busy = run_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[rtl/barrett_radix_digit_split.sv]
// Splits one dividend into base_value digits, lowest first, one beat per digit on
// result_valid; the receiver cannot stall, so each beat is on the ports for a single
// cycle and must be taken then. A dividend is taken when start is high and busy low;
// busy stays high until the final quotient beat, which carries last_digit. Each Barrett
// digit is paced by the one 32x32 multiplier being used six times per digit (four
// partial products for the high half, two for quotient times base) behind its two-stage
// accumulate. With divide_first set the first digit instead goes through the
// one-bit-per-cycle divider (or skips it if base_value is zero). Configuration is
// written through cfg_we/cfg_addr/cfg_wdata; the user must do so only while busy is
// low, and the block itself does not enforce this.
`default_nettype none

module barrett_radix_digit_split
    import brds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] dividend,
    output logic             result_valid,
    output logic      [31:0] digit,
    output logic      [5:0]  digit_index,
    output logic             last_digit
);

    localparam logic [2:0] REG_BASE    = 3'd0;
    localparam logic [2:0] REG_DCOUNT  = 3'd1;
    localparam logic [2:0] REG_RECIP   = 3'd2;
    localparam logic [2:0] REG_SHIFT   = 3'd3;
    localparam logic [2:0] REG_INMODE  = 3'd4;
    localparam logic [2:0] REG_OUTMODE = 3'd5;
    localparam logic [2:0] REG_DIVF    = 3'd6;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_M0    = 4'd1;
    localparam logic [3:0] S_M1    = 4'd2;
    localparam logic [3:0] S_M2    = 4'd3;
    localparam logic [3:0] S_M3    = 4'd4;
    localparam logic [3:0] S_MW    = 4'd5;
    localparam logic [3:0] S_SHIFT = 4'd6;
    localparam logic [3:0] S_QB0   = 4'd7;
    localparam logic [3:0] S_QB1   = 4'd8;
    localparam logic [3:0] S_QW    = 4'd9;
    localparam logic [3:0] S_REM   = 4'd10;
    localparam logic [3:0] S_DIVGO = 4'd11;
    localparam logic [3:0] S_DIVW  = 4'd12;
    localparam logic [3:0] S_LAST  = 4'd13;

    // configuration
    logic [31:0]      base_reg;
    logic [CNT_W-1:0] dcount_reg;
    logic [63:0]      recip_reg;
    logic [5:0]       shamt_reg;
    logic [1:0]       inmode_reg;
    logic [1:0]       outmode_reg;
    logic             divf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= 32'd2;
            dcount_reg  <= CNT_W'(1);
            recip_reg   <= '0;
            shamt_reg   <= '0;
            inmode_reg  <= IN_W32;
            outmode_reg <= OUT_W8;
            divf_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_BASE:    base_reg    <= cfg_wdata[31:0];
                REG_DCOUNT:  dcount_reg  <= cfg_wdata[CNT_W-1:0];
                REG_RECIP:   recip_reg   <= cfg_wdata;
                REG_SHIFT:   shamt_reg   <= cfg_wdata[5:0];
                REG_INMODE:  inmode_reg  <= cfg_wdata[1:0];
                REG_OUTMODE: outmode_reg <= cfg_wdata[1:0];
                REG_DIVF:    divf_reg    <= cfg_wdata[0];
                default:     ;
            endcase
        end
    end

    // sequencer state
    logic [3:0]       state_reg,  state_next;
    logic [63:0]      x_reg,      x_next;
    logic [63:0]      q_reg,      q_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic [IDX_W-1:0] k_reg,      k_next;
    logic             vld_reg,    vld_next;
    logic [31:0]      digit_reg,  digit_next;
    logic [IDX_W-1:0] idx_reg,    idx_next;
    logic             last_reg,   last_next;

    mac_cmd_t    mac_cmd;
    logic [31:0] mac_a;
    logic [31:0] mac_b;
    logic [63:0] mac_acc;

    logic        div_start;
    div_stat_t   div_stat;
    logic [63:0] div_quo;
    logic [31:0] div_rem;

    logic             accept;
    logic [CNT_W-1:0] total;
    logic             more_steps;

    brds_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .acc   (mac_acc)
    );

    brds_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (x_reg),
        .divisor   (base_reg),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign total      = digit_total(dcount_reg);
    // another remainder digit follows the one being emitted
    assign more_steps = (CNT_W'(k_reg) + CNT_W'(2)) < cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        vld_next   = 1'b0;
        digit_next = digit_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        mac_cmd    = '{vld: 1'b0, op: MAC_LOAD};
        mac_a      = x_reg[31:0];
        mac_b      = recip_reg[31:0];
        div_start  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_next   = in_trim(inmode_reg, dividend);
                    cnt_next = total;
                    k_next   = '0;
                    if (total == CNT_W'(1))
                        state_next = S_LAST;
                    else if (divf_reg)
                        state_next = S_DIVGO;
                    else
                        state_next = S_M0;
                end
            end
            S_M0:
            begin
                mac_cmd    = '{vld: 1'b1, op: MAC_LOAD_HI};
                state_next = S_M1;
            end
            S_M1:
            begin
                mac_cmd    = '{vld: 1'b1, op: MAC_ADD};
                mac_b      = recip_reg[63:32];
                state_next = S_M2;
            end
            S_M2:
            begin
                mac_cmd    = '{vld: 1'b1, op: MAC_ADD};
                mac_a      = x_reg[63:32];
                state_next = S_M3;
            end
            S_M3:
            begin
                mac_cmd    = '{vld: 1'b1, op: MAC_FOLD};
                mac_a      = x_reg[63:32];
                mac_b      = recip_reg[63:32];
                state_next = S_MW;
            end
            S_MW:
                state_next = S_SHIFT;
            S_SHIFT:
            begin
                q_next     = mac_acc >> shamt_reg;
                state_next = S_QB0;
            end
            S_QB0:
            begin
                mac_cmd    = '{vld: 1'b1, op: MAC_LOAD};
                mac_a      = q_reg[31:0];
                mac_b      = base_reg;
                state_next = S_QB1;
            end
            S_QB1:
            begin
                mac_cmd    = '{vld: 1'b1, op: MAC_ADD_HI};
                mac_a      = q_reg[63:32];
                mac_b      = base_reg;
                state_next = S_QW;
            end
            S_QW:
                state_next = S_REM;
            S_REM:
            begin
                vld_next   = 1'b1;
                digit_next = out_trim(outmode_reg, x_reg - mac_acc);
                idx_next   = k_reg;
                last_next  = 1'b0;
                x_next     = q_reg;
                k_next     = k_reg + IDX_W'(1);
                state_next = more_steps ? S_M0 : S_LAST;
            end
            S_DIVGO:
            begin
                if (base_reg == '0)
                begin
                    // zero base: quotient all ones, remainder the dividend
                    vld_next   = 1'b1;
                    digit_next = out_trim(outmode_reg, x_reg);
                    idx_next   = k_reg;
                    last_next  = 1'b0;
                    x_next     = '1;
                    k_next     = k_reg + IDX_W'(1);
                    state_next = more_steps ? S_M0 : S_LAST;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (div_stat.done)
                begin
                    vld_next   = 1'b1;
                    digit_next = out_trim(outmode_reg, {32'h0, div_rem});
                    idx_next   = k_reg;
                    last_next  = 1'b0;
                    x_next     = div_quo;
                    k_next     = k_reg + IDX_W'(1);
                    state_next = more_steps ? S_M0 : S_LAST;
                end
            end
            S_LAST:
            begin
                vld_next   = 1'b1;
                digit_next = out_trim(outmode_reg, x_reg);
                idx_next   = k_reg;
                last_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        k_reg     <= k_next;
        digit_reg <= digit_next;
        idx_reg   <= idx_next;
        last_reg  <= last_next;
    end

    assign result_valid = vld_reg;
    assign digit        = digit_reg;
    assign digit_index  = idx_reg;
    assign last_digit   = last_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted dividend did not make the block busy");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_digit) |-> !busy)
        else $error("final quotient beat while still busy");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_digit) |-> busy)
        else $error("remainder beat without a following quotient");

    a_div_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVW) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on divider that is not running");

endmodule

`default_nettype wire
